>>> hw/rtl/differential_drive_ramp_mixer_macros.svh
// ----------------------------------------------------------------------------
// differential drive ramp mixer assertion macros
// shared clocked assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_RAMP_MIXER_MACROS_SVH
`define DIFFERENTIAL_DRIVE_RAMP_MIXER_MACROS_SVH

// clocked assertion, off while reset is held
`define DDRM_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also watches reset itself
`define DDRM_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ddrm_pkg.sv
// ----------------------------------------------------------------------------
// ddrm_pkg
// shared types, widths and codes of the ramp mixer
// ----------------------------------------------------------------------------
`default_nettype none

package ddrm_pkg;

    localparam int unsigned CODE_W     = 5;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DRIVE_W    = 8;
    localparam int unsigned SPEED_W    = 9;
    localparam int unsigned LEVEL_W    = 7;
    localparam int unsigned FRAC_W     = 8;
    localparam int unsigned GAIN_W     = 9;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned Q_SHIFT    = 8;
    localparam int unsigned BASE_W     = LEVEL_W + GAIN_W - Q_SHIFT;

    localparam logic [GAIN_W-1:0]            TURN_SCALE_Q8    = 9'd256;
    localparam logic [INTERVAL_W-1:0]        STOP_INTERVAL_MS = 16'd20;
    localparam logic signed [SPEED_W-1:0]    BACKWARD_TARGET  = -9'sd20;
    localparam logic [DRIVE_W-2:0]           DRIVE_MAX        = '1;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t CMD_LEVEL_SLOW   = 5'd1;
    localparam code_t CMD_LEVEL_MEDIUM = 5'd2;
    localparam code_t CMD_LEVEL_FAST   = 5'd3;
    localparam code_t CMD_FORWARD      = 5'd4;
    localparam code_t CMD_BACKWARD     = 5'd5;
    localparam code_t CMD_STOP         = 5'd6;
    localparam code_t CMD_LEFT_ONE     = 5'd11;
    localparam code_t CMD_LEFT_TWO     = 5'd12;
    localparam code_t CMD_LEFT_THREE   = 5'd13;
    localparam code_t CMD_RIGHT_ONE    = 5'd14;
    localparam code_t CMD_RIGHT_TWO    = 5'd15;
    localparam code_t CMD_RIGHT_THREE  = 5'd16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_LEVEL_SLOW    = 3'd0;
    localparam cfg_idx_t REG_LEVEL_MEDIUM  = 3'd1;
    localparam cfg_idx_t REG_LEVEL_FAST    = 3'd2;
    localparam cfg_idx_t REG_TURN_ONE      = 3'd3;
    localparam cfg_idx_t REG_TURN_TWO      = 3'd4;
    localparam cfg_idx_t REG_TURN_THREE    = 3'd5;
    localparam cfg_idx_t REG_TRIM_GAIN     = 3'd6;
    localparam cfg_idx_t REG_MOVE_INTERVAL = 3'd7;

    typedef enum logic [1:0] {
        LEVEL_SLOW,
        LEVEL_MEDIUM,
        LEVEL_FAST
    } level_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIFF,
        ST_STEP,
        ST_TRIM
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic diff;
        logic step;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic fire;
        logic emit;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ddrm_ctrl.sv
// ----------------------------------------------------------------------------
// ddrm_ctrl
// sequencer of the ramp mixer and output valid tracking
// ----------------------------------------------------------------------------
`default_nettype none

module ddrm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ddrm_pkg::dp_cmd_t    cmd,
    input  ddrm_pkg::dp_status_t status
);
    import ddrm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.emit ? ST_DIFF : ST_IDLE;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_TRIM;
            end
            ST_TRIM: begin
                // wait here while the output register holds a result that m_ready does not take
                if (!m_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ddrm_datapath.sv
// ----------------------------------------------------------------------------
// ddrm_datapath
// config registers, ramp state, turn mixing and trim multiply
// ----------------------------------------------------------------------------
`default_nettype none

module ddrm_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ddrm_pkg::dp_cmd_t                     cmd,
    output ddrm_pkg::dp_status_t                  status,
    input  ddrm_pkg::code_t                       s_command_code,
    input  logic [ddrm_pkg::TIME_W-1:0]           s_now_ms,
    input  logic                                  cfg_wr_en,
    input  ddrm_pkg::cfg_idx_t                    cfg_index,
    input  logic [ddrm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic signed [ddrm_pkg::DRIVE_W-1:0]   m_left_drive,
    output logic signed [ddrm_pkg::DRIVE_W-1:0]   m_right_drive
);
    import ddrm_pkg::*;

    function automatic logic signed [SPEED_W-1:0] step_toward(
        input logic signed [SPEED_W-1:0] s,
        input logic signed [SPEED_W-1:0] t
    );
        if (s > t) begin
            step_toward = s - 9'sd1;
        end else if (s < t) begin
            step_toward = s + 9'sd1;
        end else begin
            step_toward = s;
        end
    endfunction

    function automatic logic [SPEED_W-1:0] magnitude(input logic signed [SPEED_W-1:0] s);
        logic signed [SPEED_W-1:0] neg;
        neg = -s;
        magnitude = s[SPEED_W-1] ? neg : s;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] to_drive(
        input logic               neg,
        input logic [SPEED_W-1:0] mag
    );
        logic [DRIVE_W-2:0] m;
        logic signed [DRIVE_W-1:0] pos;
        m   = (mag > SPEED_W'(DRIVE_MAX)) ? DRIVE_MAX : mag[DRIVE_W-2:0];
        pos = $signed({1'b0, m});
        to_drive = neg ? -pos : pos;
    endfunction

    // configuration
    logic [LEVEL_W-1:0]    level_slow_reg, level_medium_reg, level_fast_reg;
    logic [FRAC_W-1:0]     turn_one_reg, turn_two_reg, turn_three_reg;
    logic [GAIN_W-1:0]     trim_gain_reg;
    logic [INTERVAL_W-1:0] move_interval_reg;

    // item and ramp state
    code_t                     code_reg;
    logic [TIME_W-1:0]         now_reg;
    level_t                    level_reg, level_next;
    code_t                     dir_reg, dir_next;
    logic signed [SPEED_W-1:0] left_speed_reg, right_speed_reg;
    logic [TIME_W-1:0]         last_update_reg;
    logic [BASE_W-1:0]         base_reg, diff_reg;
    logic signed [DRIVE_W-1:0] left_out_reg, right_out_reg;

    // eval stage
    logic                         moving, due, at_rest;
    logic [INTERVAL_W-1:0]        interval;
    logic [TIME_W-1:0]            elapsed;
    logic [LEVEL_W-1:0]           level_val_next, level_val;
    logic [LEVEL_W+GAIN_W-1:0]    base_prod;

    // diff stage
    logic [FRAC_W-1:0]            frac;
    logic [BASE_W+FRAC_W-1:0]     diff_prod;

    // step stage
    logic [BASE_W:0]              hi_sum;
    logic [BASE_W-1:0]            hi_val, lo_val;
    logic signed [SPEED_W-1:0]    left_tgt, right_tgt;

    // trim stage
    logic                         trim_left, trim_right;
    logic [SPEED_W-1:0]           left_mag, right_mag, trim_in;
    logic [SPEED_W+GAIN_W-1:0]    trim_prod;
    logic [SPEED_W-1:0]           trim_mag, left_val, right_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_slow_reg    <= 7'd32;
            level_medium_reg  <= 7'd64;
            level_fast_reg    <= 7'd96;
            turn_one_reg      <= 8'd64;
            turn_two_reg      <= 8'd128;
            turn_three_reg    <= 8'd192;
            trim_gain_reg     <= 9'd256;
            move_interval_reg <= 16'd20;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LEVEL_SLOW:    level_slow_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_MEDIUM:  level_medium_reg  <= cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_FAST:    level_fast_reg    <= cfg_wdata[LEVEL_W-1:0];
                REG_TURN_ONE:      turn_one_reg      <= cfg_wdata[FRAC_W-1:0];
                REG_TURN_TWO:      turn_two_reg      <= cfg_wdata[FRAC_W-1:0];
                REG_TURN_THREE:    turn_three_reg    <= cfg_wdata[FRAC_W-1:0];
                REG_TRIM_GAIN:     trim_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_MOVE_INTERVAL: move_interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // level and direction latch
    always_comb begin
        unique case (code_reg)
            CMD_LEVEL_SLOW:   level_next = LEVEL_SLOW;
            CMD_LEVEL_MEDIUM: level_next = LEVEL_MEDIUM;
            CMD_LEVEL_FAST:   level_next = LEVEL_FAST;
            default:          level_next = level_reg;
        endcase
        unique case (code_reg) inside
            [CMD_FORWARD:CMD_RIGHT_THREE]: dir_next = code_reg;
            default:                       dir_next = dir_reg;
        endcase
        unique case (dir_next) inside
            CMD_FORWARD, CMD_BACKWARD, CMD_STOP,
            [CMD_LEFT_ONE:CMD_RIGHT_THREE]: moving = 1'b1;
            default:                        moving = 1'b0;
        endcase
    end

    always_comb begin
        unique case (level_next)
            LEVEL_SLOW:   level_val_next = level_slow_reg;
            LEVEL_MEDIUM: level_val_next = level_medium_reg;
            default:      level_val_next = level_fast_reg;
        endcase
        unique case (level_reg)
            LEVEL_SLOW:   level_val = level_slow_reg;
            LEVEL_MEDIUM: level_val = level_medium_reg;
            default:      level_val = level_fast_reg;
        endcase
    end

    assign interval  = (dir_next == CMD_STOP) ? STOP_INTERVAL_MS : move_interval_reg;
    assign elapsed   = now_reg - last_update_reg;
    assign due       = elapsed > TIME_W'(interval);
    assign at_rest   = (left_speed_reg == '0) && (right_speed_reg == '0);
    assign base_prod = (LEVEL_W+GAIN_W)'(level_val_next) * (LEVEL_W+GAIN_W)'(TURN_SCALE_Q8);

    assign status.fire = moving && due;
    assign status.emit = moving && due && !((dir_next == CMD_STOP) && at_rest);

    // turn differential
    always_comb begin
        unique case (dir_reg) inside
            CMD_LEFT_ONE, CMD_RIGHT_ONE: frac = turn_one_reg;
            CMD_LEFT_TWO, CMD_RIGHT_TWO: frac = turn_two_reg;
            default:                     frac = turn_three_reg;
        endcase
    end

    assign diff_prod = (BASE_W+FRAC_W)'(base_reg) * (BASE_W+FRAC_W)'(frac);

    // outer wheel target clamps at full scale, inner one never goes negative
    assign hi_sum = {1'b0, base_reg} + {1'b0, diff_reg};
    assign hi_val = hi_sum[BASE_W] ? '1 : hi_sum[BASE_W-1:0];
    assign lo_val = base_reg - diff_reg;

    always_comb begin
        unique case (dir_reg) inside
            CMD_FORWARD: begin
                left_tgt  = $signed({2'b00, level_val});
                right_tgt = $signed({2'b00, level_val});
            end
            CMD_BACKWARD: begin
                left_tgt  = BACKWARD_TARGET;
                right_tgt = BACKWARD_TARGET;
            end
            [CMD_LEFT_ONE:CMD_LEFT_THREE]: begin
                left_tgt  = $signed({1'b0, lo_val});
                right_tgt = $signed({1'b0, hi_val});
            end
            [CMD_RIGHT_ONE:CMD_RIGHT_THREE]: begin
                left_tgt  = $signed({1'b0, hi_val});
                right_tgt = $signed({1'b0, lo_val});
            end
            default: begin
                left_tgt  = '0;
                right_tgt = '0;
            end
        endcase
    end

    // one shared trim multiplier, at most one wheel is trimmed per direction
    always_comb begin
        unique case (dir_reg) inside
            CMD_BACKWARD: begin
                trim_left  = 1'b1;
                trim_right = 1'b0;
            end
            CMD_FORWARD, [CMD_LEFT_ONE:CMD_LEFT_THREE]: begin
                trim_left  = 1'b0;
                trim_right = 1'b1;
            end
            default: begin
                trim_left  = 1'b0;
                trim_right = 1'b0;
            end
        endcase
    end

    assign left_mag  = magnitude(left_speed_reg);
    assign right_mag = magnitude(right_speed_reg);
    assign trim_in   = trim_left ? left_mag : right_mag;
    assign trim_prod = (SPEED_W+GAIN_W)'(trim_in) * (SPEED_W+GAIN_W)'(trim_gain_reg);
    assign trim_mag  = trim_prod[Q_SHIFT +: SPEED_W];
    assign left_val  = trim_left ? trim_mag : left_mag;
    assign right_val = trim_right ? trim_mag : right_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= LEVEL_SLOW;
            dir_reg         <= '0;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
            last_update_reg <= '0;
        end else begin
            if (cmd.eval) begin
                level_reg <= level_next;
                dir_reg   <= dir_next;
                if (status.fire) begin
                    last_update_reg <= now_reg;
                end
            end
            if (cmd.step) begin
                left_speed_reg  <= step_toward(left_speed_reg, left_tgt);
                right_speed_reg <= step_toward(right_speed_reg, right_tgt);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg <= s_command_code;
            now_reg  <= s_now_ms;
        end
        if (cmd.eval) begin
            base_reg <= base_prod[Q_SHIFT +: BASE_W];
        end
        if (cmd.diff) begin
            diff_reg <= diff_prod[Q_SHIFT +: BASE_W];
        end
        if (cmd.load) begin
            left_out_reg  <= to_drive(left_speed_reg[SPEED_W-1], left_val);
            right_out_reg <= to_drive(right_speed_reg[SPEED_W-1], right_val);
        end
    end

    assign m_left_drive  = left_out_reg;
    assign m_right_drive = right_out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/differential_drive_ramp_mixer.sv
// ----------------------------------------------------------------------------
// differential_drive_ramp_mixer
// slew limited two wheel drive mixer with per direction wheel trim
// order: a command that steps the ramp shows its drive pair after the four
//   step sequence (eval, turn multiply, ramp step, trim multiply) in the
//   controller; one that steps nothing frees the input after eval; no new
//   transfer is taken before the last one is through, trim may wait on m_ready
// reset: synchronous active low aresetn restores register defaults, slow
//   level, no latched motion, zero speeds and a zero update time
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_ramp_mixer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // command input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ddrm_pkg::CODE_W-1:0]           s_command_code,
    input  logic [ddrm_pkg::TIME_W-1:0]           s_now_ms,
    // drive output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ddrm_pkg::DRIVE_W-1:0]   m_left_drive,
    output logic signed [ddrm_pkg::DRIVE_W-1:0]   m_right_drive,
    // register writes
    input  logic                                  cfg_wr_en,
    input  logic [ddrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ddrm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import ddrm_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: takes one transfer in idle, then walks eval and, if it emits, diff, step and
    // trim; the output register decouples the last step from m_ready, so a
    // waiting result only holds the sequencer when a newer one is ready
    ddrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath: register file, interval check, turn mixing, ramp speeds,
    // trim multiply and saturating drive output register
    ddrm_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_command_code (s_command_code),
        .s_now_ms       (s_now_ms),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .m_left_drive   (m_left_drive),
        .m_right_drive  (m_right_drive)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ddrm_checker.sv
// ----------------------------------------------------------------------------
// ddrm_checker
// port level properties of the ramp mixer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_ramp_mixer_macros.svh"

module ddrm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [ddrm_pkg::DRIVE_W-1:0]   m_left_drive,
    input logic signed [ddrm_pkg::DRIVE_W-1:0]   m_right_drive
);

    // a stalled result stays put
    `DDRM_ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_left_drive) && $stable(m_right_drive), "drive result changed while stalled")

    // reset leaves no result and an open input
    `DDRM_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !m_valid && s_ready, "reset did not clear the handshake state")

    // the input closes while an item is being worked on
    `DDRM_ASSERT_CLK(a_busy_after_take, aclk, aresetn, s_valid && s_ready |=> !s_ready && !$rose(m_valid), "input reopened or result appeared too early")

    // saturation never yields the most negative code
    `DDRM_ASSERT_CLK(a_drive_range, aclk, aresetn, m_valid |-> m_left_drive != 8'sh80 && m_right_drive != 8'sh80, "drive value outside saturation range")

endmodule

bind differential_drive_ramp_mixer ddrm_checker u_ddrm_checker (.*);

`default_nettype wire
